[hw/rtl/ccbp_pkg.sv]
// Shared constants for the car command byte parser.
// Byte codes, turn codes, config register map and widths; no dependencies.
package ccbp_pkg;

	localparam int unsigned ADDR_W  = 3;
	localparam int unsigned DATA_W  = 32;
	localparam int unsigned GAIN_W  = 6;
	localparam int unsigned DRIVE_W = 15;
	localparam int unsigned MAG_W   = 14;

	localparam logic [GAIN_W-1:0] GAIN_RESET = 6'd20;

	localparam logic REG_GAIN = 1'b0;

	localparam logic [7:0] BYTE_FRAME_START = 8'hFC;
	localparam logic [7:0] BYTE_FRAME_END   = 8'hFD;
	localparam logic [7:0] CHAR_E    = 8'h45;
	localparam logic [7:0] CHAR_Y    = 8'h59;
	localparam logic [7:0] CHAR_L    = 8'h4C;
	localparam logic [7:0] CHAR_R    = 8'h52;
	localparam logic [7:0] CHAR_ONE  = 8'h31;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	localparam logic [1:0] TURN_STRAIGHT = 2'd0;
	localparam logic [1:0] TURN_LEFT     = 2'd1;
	localparam logic [1:0] TURN_RIGHT    = 2'd2;

	localparam logic [2:0] FRAME_IDLE = 3'd0;
	localparam logic [2:0] FRAME_LAST = 3'd5;

endpackage

[hw/rtl/ccbp_if.sv]
// Valid/ready channel interfaces for the car command byte parser.
// Depends on ccbp_pkg for field widths.
interface ccbp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ccbp_result_if;
	import ccbp_pkg::*;

	logic                      valid;
	logic                      ready;
	logic                      led_on;
	logic [1:0]                turn_dir;
	logic                      stop_flag;
	logic                      command_done;
	logic                      drive_update;
	logic signed [DRIVE_W-1:0] left_drive;
	logic signed [DRIVE_W-1:0] right_drive;

	modport source (output valid, output led_on, output turn_dir, output stop_flag,
		output command_done, output drive_update, output left_drive,
		output right_drive, input ready);
	modport sink (input valid, input led_on, input turn_dir, input stop_flag,
		input command_done, input drive_update, input left_drive,
		input right_drive, output ready);
endinterface

[hw/rtl/car_command_byte_parser.sv]
// Car command byte parser: text commands and binary motor frames, one byte per item.
// Depends on ccbp_pkg and the channel interfaces in ccbp_if.sv.
//
//  channel | dir | handshake      | payload
//  rx      | in  | valid / ready  | rx_byte
//  res     | out | valid / ready  | led_on turn_dir stop_flag command_done
//          |     |                | drive_update left_drive right_drive
//  apb     | in  | psel / penable | drive_gain at byte address 0
//
// One item per cycle sustained while res is ready, through input and result registers.
// Decode, payload capture and the two 8x6 gain multiplies sit between those registers.
// Reset clears decoder state and sets drive_gain to 20; frame payload is not reset.
// A stalled result register holds the input register, which deasserts rx ready once full.
module car_command_byte_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	ccbp_byte_if.sink                    rx,
	ccbp_result_if.source                res,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [ccbp_pkg::ADDR_W-1:0]  paddr,
	input  logic [ccbp_pkg::DATA_W-1:0]  pwdata,
	output logic [ccbp_pkg::DATA_W-1:0]  prdata,
	output logic                         pready
);
	import ccbp_pkg::*;

	logic [GAIN_W-1:0] gain_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       advance;
	logic       fire_s1;

	logic [2:0] frame_pos_q;
	logic [7:0] payload_q [4];
	logic       stop_armed_q;
	logic       turn_armed_q;
	logic       led_armed_q;
	logic       led_q;
	logic [1:0] turn_q;
	logic       stop_q;

	logic [2:0] frame_pos_n;
	logic       stop_armed_n;
	logic       turn_armed_n;
	logic       led_armed_n;
	logic       led_n;
	logic [1:0] turn_n;
	logic       stop_n;
	logic       done;
	logic       upd;
	logic       pay_we;
	logic [1:0] pay_idx;

	logic [MAG_W-1:0]   mag_l;
	logic [MAG_W-1:0]   mag_r;
	logic [DRIVE_W-1:0] pos_l;
	logic [DRIVE_W-1:0] pos_r;
	logic [DRIVE_W-1:0] drv_l;
	logic [DRIVE_W-1:0] drv_r;

	logic                      out_valid_s2;
	logic                      led_s2;
	logic [1:0]                turn_s2;
	logic                      stop_s2;
	logic                      done_s2;
	logic                      upd_s2;
	logic signed [DRIVE_W-1:0] left_s2;
	logic signed [DRIVE_W-1:0] right_s2;

	// configuration port
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_GAIN) begin
			prdata = DATA_W'(gain_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (psel && penable && pwrite && paddr[2] == REG_GAIN) begin
			gain_q <= pwdata[GAIN_W-1:0];
		end
	end

	// handshake
	assign advance  = !out_valid_s2 || res.ready;
	assign fire_s1  = valid_s1 && advance;
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// decode
	assign pay_idx = frame_pos_q[1:0] - 2'd1;

	always_comb begin
		frame_pos_n  = frame_pos_q;
		stop_armed_n = stop_armed_q;
		turn_armed_n = turn_armed_q;
		led_armed_n  = led_armed_q;
		led_n        = led_q;
		turn_n       = turn_q;
		stop_n       = stop_q;
		done         = 1'b0;
		upd          = 1'b0;
		pay_we       = 1'b0;
		if (frame_pos_q != FRAME_IDLE) begin
			if (frame_pos_q >= FRAME_LAST) begin
				if (byte_s1 == BYTE_FRAME_END) begin
					upd    = 1'b1;
					stop_n = 1'b0;
				end
				frame_pos_n = FRAME_IDLE;
			end else begin
				pay_we      = 1'b1;
				frame_pos_n = frame_pos_q + 3'd1;
			end
		end else if (byte_s1 == CHAR_E || stop_armed_q) begin
			if (byte_s1 == CHAR_E) begin
				stop_armed_n = 1'b1;
			end else begin
				stop_n       = 1'b1;
				done         = 1'b1;
				stop_armed_n = 1'b0;
			end
		end else if (byte_s1 == CHAR_Y || turn_armed_q) begin
			if (byte_s1 == CHAR_Y) begin
				turn_armed_n = 1'b1;
			end else begin
				if (byte_s1 == CHAR_L) begin
					turn_n = TURN_LEFT;
					done   = 1'b1;
				end else if (byte_s1 == CHAR_R) begin
					turn_n = TURN_RIGHT;
					done   = 1'b1;
				end else if (byte_s1 == CHAR_ZERO) begin
					turn_n = TURN_STRAIGHT;
					done   = 1'b1;
				end
				turn_armed_n = 1'b0;
			end
		end else if (byte_s1 == CHAR_L || led_armed_q) begin
			if (byte_s1 == CHAR_L) begin
				led_armed_n = 1'b1;
			end else begin
				if (byte_s1 == CHAR_ONE) begin
					led_n = 1'b1;
					done  = 1'b1;
				end else if (byte_s1 == CHAR_ZERO) begin
					led_n = 1'b0;
					done  = 1'b1;
				end
				led_armed_n = 1'b0;
			end
		end else if (byte_s1 == BYTE_FRAME_START) begin
			frame_pos_n = 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_pos_q  <= FRAME_IDLE;
			stop_armed_q <= 1'b0;
			turn_armed_q <= 1'b0;
			led_armed_q  <= 1'b0;
			led_q        <= 1'b0;
			turn_q       <= TURN_STRAIGHT;
			stop_q       <= 1'b0;
		end else if (fire_s1) begin
			frame_pos_q  <= frame_pos_n;
			stop_armed_q <= stop_armed_n;
			turn_armed_q <= turn_armed_n;
			led_armed_q  <= led_armed_n;
			led_q        <= led_n;
			turn_q       <= turn_n;
			stop_q       <= stop_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && pay_we) begin
			payload_q[pay_idx] <= byte_s1;
		end
	end

	// drive values
	assign mag_l = MAG_W'(payload_q[1]) * MAG_W'(gain_q);
	assign mag_r = MAG_W'(payload_q[3]) * MAG_W'(gain_q);
	assign pos_l = {1'b0, mag_l};
	assign pos_r = {1'b0, mag_r};
	assign drv_l = (payload_q[0] != 8'd0) ? (DRIVE_W'(0) - pos_l) : pos_l;
	assign drv_r = (payload_q[2] != 8'd0) ? (DRIVE_W'(0) - pos_r) : pos_r;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			led_s2   <= led_n;
			turn_s2  <= turn_n;
			stop_s2  <= stop_n;
			done_s2  <= done;
			upd_s2   <= upd;
			left_s2  <= upd ? signed'(drv_l) : '0;
			right_s2 <= upd ? signed'(drv_r) : '0;
		end
	end

	assign res.valid        = out_valid_s2;
	assign res.led_on       = led_s2;
	assign res.turn_dir     = turn_s2;
	assign res.stop_flag    = stop_s2;
	assign res.command_done = done_s2;
	assign res.drive_update = upd_s2;
	assign res.left_drive   = left_s2;
	assign res.right_drive  = right_s2;

	// checks
	a_pulse_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.command_done && res.drive_update))
		else $error("text and frame pulses together");

	a_drive_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.drive_update) |-> (res.left_drive == '0 && res.right_drive == '0))
		else $error("drive values without update");

	a_update_clears_stop: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.drive_update) |-> !res.stop_flag)
		else $error("stop still set after motor frame");

	a_frame_range: assert property (@(posedge clk) disable iff (!arst_n)
		frame_pos_q <= FRAME_LAST)
		else $error("frame position out of range");

	a_frame_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!fire_s1 |=> $stable(frame_pos_q))
		else $error("frame position moved without an item");

endmodule

[dv/ccbp_checker.sv]
`timescale 1ns / 1ps
// Checker for the car command byte parser: decodes every accepted byte on its own
// and compares each result item with the oldest expected status. Uses ccbp_pkg and ccbp_if.sv.
module ccbp_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	ccbp_byte_if                        rx,
	ccbp_result_if                      res,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [ccbp_pkg::ADDR_W-1:0] paddr,
	input  logic [ccbp_pkg::DATA_W-1:0] pwdata,
	output int                          error_count,
	output int                          pending
);
	import ccbp_pkg::*;

	localparam logic [ADDR_W-1:0] GAIN_ADDR = ADDR_W'(4 * REG_GAIN);

	typedef struct packed {
		logic                      led_on;
		logic [1:0]                turn_dir;
		logic                      stop_flag;
		logic                      command_done;
		logic                      drive_update;
		logic signed [DRIVE_W-1:0] left_drive;
		logic signed [DRIVE_W-1:0] right_drive;
	} car_status_t;

	car_status_t       expected_status_q[$];
	logic [GAIN_W-1:0] gain;
	logic [2:0]        frame_pos;
	logic [7:0]        payload[4];
	logic              stop_armed;
	logic              turn_armed;
	logic              led_armed;
	logic              led_q;
	logic [1:0]        turn_q;
	logic              stop_q;

	function automatic logic signed [DRIVE_W-1:0] scaled_drive(input logic [7:0] dir,
			input logic [7:0] speed);
		logic [DRIVE_W-1:0] mag;
		mag = DRIVE_W'(speed) * DRIVE_W'(gain);
		return (dir != 8'd0) ? -mag : mag;
	endfunction

	function automatic car_status_t next_status(input logic [7:0] b);
		car_status_t r;
		r = '0;
		if (frame_pos != FRAME_IDLE) begin
			if (frame_pos >= FRAME_LAST) begin
				if (b == BYTE_FRAME_END) begin
					r.left_drive   = scaled_drive(payload[0], payload[1]);
					r.right_drive  = scaled_drive(payload[2], payload[3]);
					r.drive_update = 1'b1;
					stop_q         = 1'b0;
				end
				frame_pos = FRAME_IDLE;
			end else begin
				payload[2'(frame_pos - 3'd1)] = b;
				frame_pos = frame_pos + 3'd1;
			end
		end else if (b == CHAR_E || stop_armed) begin
			if (b == CHAR_E) begin
				stop_armed = 1'b1;
			end else begin
				stop_q         = 1'b1;
				r.command_done = 1'b1;
				stop_armed     = 1'b0;
			end
		end else if (b == CHAR_Y || turn_armed) begin
			if (b == CHAR_Y) begin
				turn_armed = 1'b1;
			end else begin
				case (b)
					CHAR_L: begin
						turn_q = TURN_LEFT;
						r.command_done = 1'b1;
					end
					CHAR_R: begin
						turn_q = TURN_RIGHT;
						r.command_done = 1'b1;
					end
					CHAR_ZERO: begin
						turn_q = TURN_STRAIGHT;
						r.command_done = 1'b1;
					end
					default: ;
				endcase
				turn_armed = 1'b0;
			end
		end else if (b == CHAR_L || led_armed) begin
			if (b == CHAR_L) begin
				led_armed = 1'b1;
			end else begin
				case (b)
					CHAR_ONE: begin
						led_q = 1'b1;
						r.command_done = 1'b1;
					end
					CHAR_ZERO: begin
						led_q = 1'b0;
						r.command_done = 1'b1;
					end
					default: ;
				endcase
				led_armed = 1'b0;
			end
		end else if (b == BYTE_FRAME_START) begin
			frame_pos = 3'd1;
		end
		r.led_on    = led_q;
		r.turn_dir  = turn_q;
		r.stop_flag = stop_q;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		car_status_t want;
		car_status_t got;
		if (!arst_n) begin
			expected_status_q.delete();
			gain        = GAIN_RESET;
			frame_pos   = FRAME_IDLE;
			payload     = '{default: 8'd0};
			stop_armed  = 1'b0;
			turn_armed  = 1'b0;
			led_armed   = 1'b0;
			led_q       = 1'b0;
			turn_q      = TURN_STRAIGHT;
			stop_q      = 1'b0;
			error_count = 0;
			pending     = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == GAIN_ADDR)
				gain = pwdata[GAIN_W-1:0];
			if (res.valid && res.ready) begin
				got.led_on       = res.led_on;
				got.turn_dir     = res.turn_dir;
				got.stop_flag    = res.stop_flag;
				got.command_done = res.command_done;
				got.drive_update = res.drive_update;
				got.left_drive   = res.left_drive;
				got.right_drive  = res.right_drive;
				if (expected_status_q.size() == 0) begin
					error_count++;
					if (error_count <= 10)
						$display("%0t: result item with no byte pending", $time);
				end else begin
					want = expected_status_q.pop_front();
					if (got !== want) begin
						error_count++;
						if (error_count <= 10) begin
							$write("%0t: mismatch exp led=%0d turn=%0d stop=%0d done=%0d upd=%0d l=%0d r=%0d",
								$time, want.led_on, want.turn_dir, want.stop_flag,
								want.command_done, want.drive_update,
								$signed(want.left_drive), $signed(want.right_drive));
							$display(" got led=%0d turn=%0d stop=%0d done=%0d upd=%0d l=%0d r=%0d",
								got.led_on, got.turn_dir, got.stop_flag, got.command_done,
								got.drive_update, $signed(got.left_drive),
								$signed(got.right_drive));
						end
					end
				end
			end
			if (rx.valid && rx.ready)
				expected_status_q.push_back(next_status(rx.rx_byte));
			pending = expected_status_q.size();
		end
	end

endmodule

[dv/tb_car_command_byte_parser.sv]
`timescale 1ns / 1ps
// Testbench top for the car command byte parser: directed and random byte streams,
// gain writes over APB, bursty sender and stalling receiver. Uses ccbp_pkg, ccbp_if.sv, ccbp_checker.
module tb_car_command_byte_parser;
	import ccbp_pkg::*;

	localparam int LIMIT      = 300000;
	localparam int LONG_HOLD  = 80;
	localparam int PHASES     = 8;
	localparam int PHASE_LEN  = 235;
	localparam logic [ADDR_W-1:0] GAIN_ADDR = ADDR_W'(4 * REG_GAIN);

	typedef enum int {SINK_FREE, SINK_COIN, SINK_SPARSE, SINK_PATTERN} sink_mode_e;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	int         error_count;
	int         pending;
	int         cycle_count;
	int         max_gap;
	int         hold_requests;
	int         holds_done;
	logic [7:0] byte_q[$];

	ccbp_byte_if   rx_ch();
	ccbp_result_if res_ch();

	car_command_byte_parser i_dut (
		.clk, .arst_n, .rx(rx_ch), .res(res_ch),
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	ccbp_checker i_checker (
		.clk, .arst_n, .rx(rx_ch), .res(res_ch),
		.psel, .penable, .pwrite, .pready, .paddr, .pwdata,
		.error_count, .pending
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_car_command_byte_parser failed");
		$finish;
	end

	initial begin
		sink_mode_e mode;
		int         span;
		int         step;
		res_ch.ready = 1'b0;
		holds_done   = 0;
		step         = 0;
		forever begin
			mode = sink_mode_e'($urandom_range(0, 3));
			span = $urandom_range(20, 150);
			repeat (span) begin
				@(negedge clk);
				if (hold_requests != holds_done) begin
					res_ch.ready = 1'b0;
					repeat (LONG_HOLD) @(negedge clk);
					holds_done++;
				end
				step++;
				case (mode)
					SINK_FREE:   res_ch.ready = 1'b1;
					SINK_COIN:   res_ch.ready = 1'($urandom_range(0, 1));
					SINK_SPARSE: res_ch.ready = ($urandom_range(0, 3) == 0);
					default:     res_ch.ready = (step % 7) < 4;
				endcase
			end
		end
	end

	task automatic send_queued();
		int burst_left;
		int gap;
		burst_left = 0;
		@(negedge clk);
		while (byte_q.size() > 0) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 24);
				gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
				if (gap > 0) begin
					rx_ch.valid = 1'b0;
					repeat (gap) @(negedge clk);
				end
			end
			rx_ch.valid   = 1'b1;
			rx_ch.rx_byte = byte_q.pop_front();
			@(posedge clk);
			while (!rx_ch.ready) @(posedge clk);
			burst_left--;
			@(negedge clk);
		end
		rx_ch.valid = 1'b0;
	endtask

	task automatic settle();
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_gain(input logic [GAIN_W-1:0] g);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = GAIN_ADDR;
		pwdata  = {(DATA_W-GAIN_W)'($urandom()), g};
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	function automatic logic [7:0] pick_trigger();
		case ($urandom_range(0, 2))
			0:       return CHAR_E;
			1:       return CHAR_Y;
			default: return CHAR_L;
		endcase
	endfunction

	function automatic logic [7:0] good_argument(input logic [7:0] trig);
		if (trig == CHAR_E)
			return 8'($urandom_range(0, 255));
		if (trig == CHAR_Y) begin
			case ($urandom_range(0, 2))
				0:       return CHAR_L;
				1:       return CHAR_R;
				default: return CHAR_ZERO;
			endcase
		end
		return ($urandom_range(0, 1) != 0) ? CHAR_ONE : CHAR_ZERO;
	endfunction

	task automatic queue_random(input int count);
		int         kind;
		logic [7:0] trig;
		while (byte_q.size() < count) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				byte_q.push_back(BYTE_FRAME_START);
				repeat (2) begin
					byte_q.push_back(($urandom_range(0, 1) != 0) ? 8'h00 :
						8'($urandom_range(1, 255)));
					byte_q.push_back(8'($urandom_range(0, 255)));
				end
				byte_q.push_back(($urandom_range(0, 9) != 0) ? BYTE_FRAME_END :
					8'($urandom_range(0, 255)));
			end else if (kind < 82) begin
				trig = pick_trigger();
				byte_q.push_back(trig);
				if (kind >= 72)
					byte_q.push_back(($urandom_range(0, 1) != 0) ? trig : pick_trigger());
				byte_q.push_back(($urandom_range(0, 4) != 0) ? good_argument(trig) :
					8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 3)) begin
					case ($urandom_range(0, 3))
						0:       byte_q.push_back(pick_trigger());
						1:       byte_q.push_back(good_argument(pick_trigger()));
						2:       byte_q.push_back(BYTE_FRAME_START);
						default: byte_q.push_back(8'($urandom_range(0, 255)));
					endcase
				end
			end
		end
	endtask

	initial begin
		logic [GAIN_W-1:0] g;
		arst_n        = 1'b0;
		rx_ch.valid   = 1'b0;
		rx_ch.rx_byte = 8'd0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		hold_requests = 0;
		max_gap       = 4;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		byte_q = '{CHAR_E, 8'h00, CHAR_Y, CHAR_L, CHAR_Y, CHAR_R, CHAR_Y, CHAR_Y, CHAR_ZERO,
			CHAR_L, CHAR_ONE, CHAR_L, 8'hFF, CHAR_L, CHAR_ZERO, CHAR_E, CHAR_E, 8'h41,
			BYTE_FRAME_START, 8'h00, 8'hFF, 8'h80, 8'hFF, BYTE_FRAME_END,
			BYTE_FRAME_START, 8'h01, 8'h80, 8'h00, 8'h7F, 8'hFE};
		send_queued();
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0:       g = 6'd63;
				1:       g = 6'd1;
				2:       g = 6'd0;
				default: g = GAIN_W'($urandom_range(1, 63));
			endcase
			write_gain(g);
			queue_random(PHASE_LEN);
			if (p == 3) begin
				max_gap = 0;
				hold_requests++;
			end else begin
				max_gap = $urandom_range(0, 8);
			end
			send_queued();
			settle();
		end

		while (pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0 && pending == 0)
			$display("tb_car_command_byte_parser passed");
		else
			$display("tb_car_command_byte_parser failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ccbp_pkg.sv
hw/rtl/ccbp_if.sv
hw/rtl/car_command_byte_parser.sv
dv/ccbp_checker.sv
dv/tb_car_command_byte_parser.sv
